### src/ehcst_pkg.sv
// Shared types and constants for the call-site table search block.
package ehcst_pkg;

   // Address arithmetic width; all address sums wrap at this width
   localparam int ADDR_W = 64;

   // Encoding bytes of the table header
   localparam logic [7:0] ENC_OMIT   = 8'hff;
   localparam logic [7:0] ENC_ULEB   = 8'h01;
   localparam logic [7:0] ENC_UDATA4 = 8'h03;

   // uleb128 shift count stops growing once it is at or above this value
   localparam logic [6:0] LEB_SHIFT_CAP = 7'd120;
   localparam logic [6:0] LEB_STEP      = 7'd7;

   // Pad kinds
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_CLEANUP   = 3'd1;
   localparam logic [2:0] KIND_CATCH     = 3'd2;
   localparam logic [2:0] KIND_BOTH      = 3'd3;
   localparam logic [2:0] KIND_TERMINATE = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_START_ENC = 3'd1;
   localparam logic [2:0] ERR_SITE_ENC  = 3'd2;
   localparam logic [2:0] ERR_ACTION    = 3'd3;
   localparam logic [2:0] ERR_TRUNC     = 3'd4;
   localparam logic [2:0] ERR_LEB       = 3'd5;

   // One input word
   typedef struct packed {
      logic [7:0]  table_byte;
      logic        first;
      logic        last;
      logic [63:0] search_ip;
      logic [63:0] region_start;
   } item_type;

   // One result word
   typedef struct packed {
      logic [2:0]  pad_kind;
      logic [63:0] pad_address;
      logic [2:0]  error_code;
   } res_type;

endpackage

### src/ehcst_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface ehcst_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  table_byte;
   logic        first;
   logic        last;
   logic [63:0] search_ip;
   logic [63:0] region_start;

   modport source (output valid, output table_byte, output first, output last,
                   output search_ip, output region_start, input ready);
   modport sink (input valid, input table_byte, input first, input last,
                 input search_ip, input region_start, output ready);
endinterface

interface ehcst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  pad_kind;
   logic [63:0] pad_address;
   logic [2:0]  error_code;

   modport source (output valid, output pad_kind, output pad_address,
                   output error_code, input ready);
   modport sink (input valid, input pad_kind, input pad_address,
                 input error_code, output ready);
endinterface

### src/ehcst_parser.sv
// Byte-at-a-time parser and call-site walker holding the search state.
module ehcst_parser
   import ehcst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  item_type item,
   output logic     res_valid,
   output res_type  res
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_LPSTART = 3'd1;
   localparam logic [2:0] PH_TTENC   = 3'd2;
   localparam logic [2:0] PH_TTOFF   = 3'd3;
   localparam logic [2:0] PH_SITEENC = 3'd4;
   localparam logic [2:0] PH_TABLEN  = 3'd5;
   localparam logic [2:0] PH_ENTRY   = 3'd6;
   localparam logic [2:0] PH_WAIT    = 3'd7;

   logic [2:0]        phase_ff, phase_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic [6:0]        shift_ff, shift_in;
   logic              uses_leb_ff, uses_leb_in;
   logic [63:0]       sbl_ff, sbl_in;
   logic [1:0]        field_ff, field_in;
   logic [1:0]        wbi_ff, wbi_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic [ADDR_W-1:0] pad_ff, pad_in;
   logic [ADDR_W-1:0] sabs_ff, sabs_in;
   logic [ADDR_W-1:0] send_ff, send_in;
   logic [ADDR_W-1:0] pad_abs_ff, pad_abs_in;
   logic [ADDR_W-1:0] ipm_ff, ipm_in;
   logic [ADDR_W-1:0] region_ff, region_in;
   logic [6:0]        action_ff, action_in;
   logic [7:0]        count_ff, count_in;

   logic [7:0]        tb;
   logic [ADDR_W+6:0] leb_wide;
   logic              leb_ovf;
   logic [ADDR_W-1:0] leb_acc;
   logic [6:0]        leb_shift_nx;
   logic [ADDR_W-1:0] word_acc;
   logic [ADDR_W-1:0] pad_sum;
   logic [63:0]       sbl_dec;

   assign tb = item.table_byte;

   // uleb128 digit: place seven payload bits, flag bits past the address width
   always_comb begin
      leb_wide = (ADDR_W + 7)'(tb[6:0]) << shift_ff;
      if (shift_ff >= 7'(ADDR_W)) begin
         leb_ovf = (tb[6:0] != 7'd0);
         leb_acc = acc_ff;
      end else begin
         leb_ovf = (leb_wide[ADDR_W+6:ADDR_W] != 7'd0);
         leb_acc = acc_ff | leb_wide[ADDR_W-1:0];
      end
      leb_shift_nx = (shift_ff < LEB_SHIFT_CAP) ? 7'(shift_ff + LEB_STEP) : shift_ff;
   end

   // little-endian 4-byte word: place the byte by its index
   assign word_acc = acc_ff | (ADDR_W'(tb) << {wbi_ff, 3'b000});
   assign pad_sum  = pad_ff + region_ff;
   assign sbl_dec  = sbl_ff - 64'd1;

   // next state and result for the current byte
   always_comb begin
      logic [2:0] cur;
      logic       done;

      phase_in    = phase_ff;
      acc_in      = acc_ff;
      shift_in    = shift_ff;
      uses_leb_in = uses_leb_ff;
      sbl_in      = sbl_ff;
      field_in    = field_ff;
      wbi_in      = wbi_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      pad_in      = pad_ff;
      sabs_in     = sabs_ff;
      send_in     = send_ff;
      pad_abs_in  = pad_abs_ff;
      ipm_in      = ipm_ff;
      region_in   = region_ff;
      action_in   = action_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res         = '0;
      done        = 1'b0;
      cur         = phase_ff;

      // start a new search on a first-marked word
      if (step && item.first) begin
         cur       = PH_LPSTART;
         ipm_in    = ADDR_W'(item.search_ip) - ADDR_W'(1);
         region_in = ADDR_W'(item.region_start);
      end

      if (step) begin
         case (cur)
            PH_LPSTART: begin
               if (tb != ENC_OMIT) begin
                  res_valid = 1'b1;
                  res.error_code = ERR_START_ENC;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_TTENC;
               end
            end
            PH_TTENC: begin
               acc_in   = '0;
               shift_in = '0;
               wbi_in   = '0;
               phase_in = (tb != ENC_OMIT) ? PH_TTOFF : PH_SITEENC;
            end
            PH_TTOFF: begin
               acc_in   = leb_acc;
               shift_in = leb_shift_nx;
               if (leb_ovf) begin
                  res_valid = 1'b1;
                  res.error_code = ERR_LEB;
                  phase_in = PH_IDLE;
               end else if (!tb[7]) begin
                  phase_in = PH_SITEENC;
               end
            end
            PH_SITEENC: begin
               if (tb == ENC_UDATA4 || tb == ENC_ULEB) begin
                  uses_leb_in = (tb == ENC_ULEB);
                  acc_in   = '0;
                  shift_in = '0;
                  wbi_in   = '0;
                  phase_in = PH_TABLEN;
               end else begin
                  res_valid = 1'b1;
                  res.error_code = ERR_SITE_ENC;
                  phase_in = PH_IDLE;
               end
            end
            PH_TABLEN: begin
               acc_in   = leb_acc;
               shift_in = leb_shift_nx;
               if (leb_ovf) begin
                  res_valid = 1'b1;
                  res.error_code = ERR_LEB;
                  phase_in = PH_IDLE;
               end else if (!tb[7]) begin
                  sbl_in = 64'(leb_acc);
                  if (leb_acc == '0) begin
                     res_valid = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     field_in = 2'd0;
                     acc_in   = '0;
                     shift_in = '0;
                     wbi_in   = '0;
                     phase_in = PH_ENTRY;
                  end
               end
            end
            PH_ENTRY: begin
               sbl_in = sbl_dec;
               if (field_ff != 2'd3) begin
                  // precompute the absolute range while later fields stream in
                  if (field_ff == 2'd1) sabs_in = start_ff + region_ff;
                  if (field_ff == 2'd2) send_in = sabs_ff + length_ff;
                  if (uses_leb_ff) begin
                     acc_in   = leb_acc;
                     shift_in = leb_shift_nx;
                     done     = !tb[7];
                  end else begin
                     acc_in = word_acc;
                     if (wbi_ff == 2'd3) done = 1'b1;
                     else wbi_in = 2'(wbi_ff + 2'd1);
                  end
                  if (uses_leb_ff && leb_ovf) begin
                     res_valid = 1'b1;
                     res.error_code = ERR_LEB;
                     phase_in = PH_IDLE;
                  end else begin
                     if (done) begin
                        case (field_ff)
                           2'd0:    start_in  = acc_in;
                           2'd1:    length_in = acc_in;
                           default: pad_in    = acc_in;
                        endcase
                        field_in = 2'(field_ff + 2'd1);
                        acc_in   = '0;
                        shift_in = '0;
                        wbi_in   = '0;
                     end
                     if (sbl_dec == 64'd0) begin
                        res_valid = 1'b1;
                        res.error_code = ERR_TRUNC;
                        phase_in = PH_IDLE;
                     end
                  end
               end else begin
                  // action byte: compare the address against this entry
                  if (tb[7]) begin
                     res_valid = 1'b1;
                     res.error_code = ERR_ACTION;
                     phase_in = PH_IDLE;
                  end else if (ipm_ff < sabs_ff) begin
                     res_valid = 1'b1;
                     res.pad_kind = KIND_TERMINATE;
                     phase_in = PH_IDLE;
                  end else if (ipm_ff < send_ff) begin
                     pad_abs_in = pad_sum;
                     if (pad_ff == '0 || tb == 8'd0) begin
                        res_valid = 1'b1;
                        res.pad_kind = (pad_ff == '0) ? KIND_NONE : KIND_CLEANUP;
                        res.pad_address = 64'(pad_sum);
                        phase_in = PH_IDLE;
                     end else begin
                        action_in = tb[6:0];
                        count_in  = 8'd0;
                        phase_in  = PH_WAIT;
                     end
                  end else if (sbl_dec == 64'd0) begin
                     res_valid = 1'b1;
                     res.pad_kind = KIND_TERMINATE;
                     phase_in = PH_IDLE;
                  end else begin
                     field_in = 2'd0;
                     acc_in   = '0;
                     shift_in = '0;
                     wbi_in   = '0;
                  end
               end
            end
            PH_WAIT: begin
               // skip the rest of the call-site table, then count to the action
               if (sbl_ff != 64'd0) begin
                  sbl_in = sbl_dec;
               end else if (count_ff == {1'b0, action_ff}) begin
                  res_valid = 1'b1;
                  res.pad_kind = (tb == 8'd0) ? KIND_CATCH : KIND_BOTH;
                  res.pad_address = 64'(pad_abs_ff);
                  phase_in = PH_IDLE;
               end else begin
                  count_in = 8'(count_ff + 8'd1);
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // flag truncation when the final byte leaves the search open
         if (!res_valid && item.last && phase_in != PH_IDLE) begin
            res_valid = 1'b1;
            res = '0;
            res.error_code = ERR_TRUNC;
            phase_in = PH_IDLE;
         end
      end
   end

   // hold the parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      acc_ff      <= acc_in;
      shift_ff    <= shift_in;
      uses_leb_ff <= uses_leb_in;
      sbl_ff      <= sbl_in;
      field_ff    <= field_in;
      wbi_ff      <= wbi_in;
      start_ff    <= start_in;
      length_ff   <= length_in;
      pad_ff      <= pad_in;
      sabs_ff     <= sabs_in;
      send_ff     <= send_in;
      pad_abs_ff  <= pad_abs_in;
      ipm_ff      <= ipm_in;
      region_ff   <= region_in;
      action_ff   <= action_in;
      count_ff    <= count_in;
   end

endmodule

### src/eh_callsite_table_search.sv
// Top level: input register, parser and two-word response buffer.
//
// Usage: stream the bytes of one exception table on req_ch, one word per
// byte. The word with first set opens a search and carries the return
// address and the region base; last marks the final available byte.
// At most one response word per search appears on rsp_ch: pad kind, pad
// address and error code. A matching entry with a nonzero pad and action
// answers on the byte at that offset past the end of the call-site table,
// or with a truncation error if last comes first. Throughput: one byte
// per cycle while the response buffer has room; the parse state advances
// once per byte through a single step of shift, add and compare logic.
// A response passes the input register, then the response buffer.
// Reset: synchronous, active high; the parser returns to idle and both
// buffers empty. Bytes without first while idle are dropped silently.
// Stall: the two-entry response buffer keeps taking bytes while one word
// waits; req_ch.ready drops only when both entries are full and the input
// register holds a byte.
module eh_callsite_table_search
   import ehcst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ehcst_req_if.sink   req_ch,
   ehcst_rsp_if.source rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       space;
   logic       step;
   logic       take;
   logic       par_valid;
   res_type    par_res;

   res_type    buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // advance the held byte when the response buffer has room
   assign space        = (count_ff != 2'd2);
   assign step         = in_valid_ff && space;
   assign req_ch.ready = !in_valid_ff || space;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_valid_in  = take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (take) begin
         item_ff.table_byte   <= req_ch.table_byte;
         item_ff.first        <= req_ch.first;
         item_ff.last         <= req_ch.last;
         item_ff.search_ip    <= req_ch.search_ip;
         item_ff.region_start <= req_ch.region_start;
      end
   end

   ehcst_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item_ff),
      .res_valid (par_valid),
      .res       (par_res)
   );

   // queue responses, drain in order
   assign push      = step && par_valid;
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= par_res;
      end
   end

   assign rsp_ch.valid       = (count_ff != 2'd0);
   assign rsp_ch.pad_kind    = buf_ff[rd_ptr_ff].pad_kind;
   assign rsp_ch.pad_address = buf_ff[rd_ptr_ff].pad_address;
   assign rsp_ch.error_code  = buf_ff[rd_ptr_ff].error_code;

endmodule
